// ----- hw/rtl/differential_drive_motion_control_top_defines.svh -----
// Assertion macros for the differential drive motion control block.
`ifndef DIFFERENTIAL_DRIVE_MOTION_CONTROL_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MOTION_CONTROL_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define DDMC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ddmc assertion failed");

`define DDMC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("ddmc reset assertion failed");

`else

`define DDMC_ASSERT(label, prop)

`define DDMC_ASSERT_RST(label, prop)

`endif

`endif

// ----- hw/rtl/ddmc_pkg.sv -----
// Types, constants and helpers shared by the motion control block.
package ddmc_pkg;

    localparam int DUTY_W   = 7;
    localparam int PROD_W   = 23;
    localparam int SCALED_W = 24;
    localparam int TGT_W    = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    localparam logic [SCALED_W-1:0] TICK_SCALE = 24'd1000;
    localparam logic [TGT_W-1:0]    MDEG_PER_DEG = 20'd1000;

    localparam logic [1:0] OP_STRAIGHT = 2'd0;
    localparam logic [1:0] OP_TURN     = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [3:0] PINS_FORWARD     = 4'b0101;
    localparam logic [3:0] PINS_BACKWARD    = 4'b1010;
    localparam logic [3:0] PINS_RIGHT_PIVOT = 4'b0110;
    localparam logic [3:0] PINS_RIGHT_SWING = 4'b0100;
    localparam logic [3:0] PINS_LEFT_PIVOT  = 4'b1001;
    localparam logic [3:0] PINS_LEFT_SWING  = 4'b0001;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_STRONG_DUTY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_WEAK_DUTY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BWD_STRONG_DUTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BWD_WEAK_DUTY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_METRE = 3'd5;

    localparam logic [6:0] RST_BASE_DUTY       = 7'd30;
    localparam logic [6:0] RST_FWD_STRONG_DUTY = 7'd40;
    localparam logic [6:0] RST_FWD_WEAK_DUTY   = 7'd25;
    localparam logic [6:0] RST_BWD_STRONG_DUTY = 7'd32;
    localparam logic [6:0] RST_BWD_WEAK_DUTY   = 7'd28;
    localparam logic [6:0] RST_TICKS_PER_METRE = 7'd16;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'b001,
        MODE_STRAIGHT = 3'b010,
        MODE_TURN     = 3'b100
    } t_mode;

    typedef struct packed {
        logic [1:0]         operation;
        logic               direction;
        logic               swing_turn;
        logic [15:0]        distance_mm;
        logic [8:0]         target_deg;
        logic signed [15:0] yaw_cdeg;
        logic signed [15:0] gyro_rate;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        bridge_pins;
        logic [DUTY_W-1:0] duty_left;
        logic [DUTY_W-1:0] duty_right;
        logic              running;
        logic              finished;
    } t_out_item;

    typedef struct packed {
        logic [6:0] base_duty;
        logic [6:0] forward_strong_duty;
        logic [6:0] forward_weak_duty;
        logic [6:0] backward_strong_duty;
        logic [6:0] backward_weak_duty;
        logic [6:0] ticks_per_metre;
    } t_cfg;

    function automatic logic [DUTY_W-1:0] duty_clamp(input logic [DUTY_W-1:0] d);
        return (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

endpackage

// ----- hw/rtl/ddmc_core.sv -----
// Motion state and per-item control step: straight, turn and idle handling.
module ddmc_core import ddmc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_mode                r_mode, n_mode;
    logic                 r_dir, n_dir;
    logic [3:0]           r_pins, n_pins;
    logic signed [15:0]   r_ref_yaw, n_ref_yaw;
    logic [PROD_W-1:0]    r_product, n_product;
    logic [SCALED_W-1:0]  r_scaled, n_scaled;
    logic [TGT_W-1:0]     r_target, n_target;
    logic signed [31:0]   r_accum, n_accum;

    logic [PROD_W-1:0]    w_product;
    logic [TGT_W-1:0]     w_target;
    logic signed [32:0]   w_sum;
    logic signed [31:0]   w_sat;
    logic signed [32:0]   w_sat33;
    logic signed [32:0]   w_tgt33;
    logic                 w_turn_done;
    logic [DUTY_W-1:0]    w_dl, w_dr;
    logic                 w_run, w_fin;

    // budget check: count >= ceil(p/1000) <=> count*1000 >= p
    assign w_product = PROD_W'(i_item.distance_mm) * PROD_W'(i_cfg.ticks_per_metre);
    assign w_target  = TGT_W'(i_item.target_deg) * MDEG_PER_DEG;

    assign w_sum = $signed({r_accum[31], r_accum})
                 + $signed({{16{i_item.gyro_rate[15]}}, i_item.gyro_rate, 1'b0});

    always_comb begin
        if (w_sum[32] != w_sum[31]) begin
            w_sat = w_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    assign w_sat33 = $signed({w_sat[31], w_sat});
    assign w_tgt33 = $signed({13'd0, r_target});
    assign w_turn_done = (r_dir == 1'b0) ? (w_sat33 <= -w_tgt33) : (w_sat33 >= w_tgt33);

    always_comb begin
        n_mode    = r_mode;
        n_dir     = r_dir;
        n_pins    = r_pins;
        n_ref_yaw = r_ref_yaw;
        n_product = r_product;
        n_scaled  = r_scaled;
        n_target  = r_target;
        n_accum   = r_accum;
        w_dl      = '0;
        w_dr      = '0;
        w_run     = 1'b0;
        w_fin     = 1'b0;
        case (i_item.operation)
            OP_STRAIGHT: begin
                n_dir     = i_item.direction;
                n_pins    = i_item.direction ? PINS_BACKWARD : PINS_FORWARD;
                n_ref_yaw = i_item.yaw_cdeg;
                n_product = w_product;
                n_scaled  = '0;
                if (w_product == '0) begin
                    n_mode = MODE_IDLE;
                    w_fin  = 1'b1;
                end else begin
                    n_mode = MODE_STRAIGHT;
                    w_dl   = i_cfg.base_duty;
                    w_dr   = i_cfg.base_duty;
                    w_run  = 1'b1;
                end
            end
            OP_TURN: begin
                n_dir = i_item.direction;
                if (!i_item.direction) begin
                    n_pins = i_item.swing_turn ? PINS_RIGHT_SWING : PINS_RIGHT_PIVOT;
                end else begin
                    n_pins = i_item.swing_turn ? PINS_LEFT_SWING : PINS_LEFT_PIVOT;
                end
                n_target = w_target;
                n_accum  = '0;
                if (w_target == '0) begin
                    n_mode = MODE_IDLE;
                    w_fin  = 1'b1;
                end else begin
                    n_mode = MODE_TURN;
                    w_dl   = i_cfg.base_duty;
                    w_dr   = i_cfg.base_duty;
                    w_run  = 1'b1;
                end
            end
            default: begin
                case (r_mode)
                    MODE_STRAIGHT: begin
                        if (r_scaled >= SCALED_W'(r_product)) begin
                            n_mode = MODE_IDLE;
                            w_fin  = 1'b1;
                        end else begin
                            n_scaled = r_scaled + TICK_SCALE;
                            w_run    = 1'b1;
                            if (i_item.yaw_cdeg == r_ref_yaw) begin
                                w_dl = i_cfg.base_duty;
                                w_dr = i_cfg.base_duty;
                            end else if (!r_dir) begin
                                if (i_item.yaw_cdeg < r_ref_yaw) begin
                                    w_dl = i_cfg.forward_strong_duty;
                                    w_dr = i_cfg.forward_weak_duty;
                                end else begin
                                    w_dl = i_cfg.forward_weak_duty;
                                    w_dr = i_cfg.forward_strong_duty;
                                end
                            end else begin
                                if (i_item.yaw_cdeg > r_ref_yaw) begin
                                    w_dl = i_cfg.backward_strong_duty;
                                    w_dr = i_cfg.backward_weak_duty;
                                end else begin
                                    w_dl = i_cfg.backward_weak_duty;
                                    w_dr = i_cfg.backward_strong_duty;
                                end
                            end
                        end
                    end
                    MODE_TURN: begin
                        n_accum = w_sat;
                        if (w_turn_done) begin
                            n_mode = MODE_IDLE;
                            w_fin  = 1'b1;
                        end else begin
                            w_dl  = i_cfg.base_duty;
                            w_dr  = i_cfg.base_duty;
                            w_run = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_dir     <= 1'b0;
            r_pins    <= '0;
            r_ref_yaw <= '0;
            r_product <= '0;
            r_scaled  <= '0;
            r_target  <= '0;
            r_accum   <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_dir     <= n_dir;
            r_pins    <= n_pins;
            r_ref_yaw <= n_ref_yaw;
            r_product <= n_product;
            r_scaled  <= n_scaled;
            r_target  <= n_target;
            r_accum   <= n_accum;
        end
    end

    assign o_result.bridge_pins = n_pins;
    assign o_result.duty_left   = duty_clamp(w_dl);
    assign o_result.duty_right  = duty_clamp(w_dr);
    assign o_result.running     = w_run;
    assign o_result.finished    = w_fin;

endmodule

// ----- hw/rtl/differential_drive_motion_control_top.sv -----
// Top level of the differential drive motion control block.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out      | output    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//  cfg      | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; an item passes
// through the input register, then the control step into the result register.
// The control step, including the 16x7 budget product and the 33-bit turn
// accumulate-and-compare, sits between the input and result registers.
// Synchronous active-low reset clears motion state and valids, loads cfg defaults.
// A stalled output holds its result; input stalls only while both stages are full
// and the output is stalled.
`include "differential_drive_motion_control_top_defines.svh"

module differential_drive_motion_control_top import ddmc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [6:0]           i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      w_in_xfer;
    logic      w_advance;
    t_out_item w_result;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_duty            <= RST_BASE_DUTY;
            r_cfg.forward_strong_duty  <= RST_FWD_STRONG_DUTY;
            r_cfg.forward_weak_duty    <= RST_FWD_WEAK_DUTY;
            r_cfg.backward_strong_duty <= RST_BWD_STRONG_DUTY;
            r_cfg.backward_weak_duty   <= RST_BWD_WEAK_DUTY;
            r_cfg.ticks_per_metre      <= RST_TICKS_PER_METRE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_DUTY:       r_cfg.base_duty            <= i_cfg_data;
                CFG_FWD_STRONG_DUTY: r_cfg.forward_strong_duty  <= i_cfg_data;
                CFG_FWD_WEAK_DUTY:   r_cfg.forward_weak_duty    <= i_cfg_data;
                CFG_BWD_STRONG_DUTY: r_cfg.backward_strong_duty <= i_cfg_data;
                CFG_BWD_WEAK_DUTY:   r_cfg.backward_weak_duty   <= i_cfg_data;
                CFG_TICKS_PER_METRE: r_cfg.ticks_per_metre      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    ddmc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `DDMC_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_out_valid)
    `DDMC_ASSERT(a_step_loads_out, w_advance |=> o_out_valid)
    `DDMC_ASSERT(a_finish_not_running, o_out_valid && o_out_data.finished |-> !o_out_data.running)
    `DDMC_ASSERT(a_stopped_zero_duty, o_out_valid && !o_out_data.running |-> o_out_data.duty_left == '0 && o_out_data.duty_right == '0)

endmodule
